FILE: rtl/psq_pkg.sv
// Shared types and constants for the positional sequence store.
// Used by the control logic, the storage cells, the top level and the checker.
// Depends on nothing.
package psq_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int COUNT_OUT_W  = 5;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_REMOVE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_REMOVE  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   pos;
  } cell_cmd_t;

endpackage

FILE: rtl/psq_ctrl.sv
// Action decode for the positional sequence store: range and capacity checks,
// the next count and the command broadcast to every storage cell.
// Depends on psq_pkg.
module psq_ctrl #(
  parameter int CAPACITY = psq_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                      accept,
  input  psq_pkg::action_t          action,
  input  logic [psq_pkg::POS_W-1:0] position,
  input  logic [CNT_W-1:0]          count,
  output psq_pkg::cell_cmd_t        cmd,
  output psq_pkg::status_t          status,
  output logic [CNT_W-1:0]          count_nxt
);

  localparam int CMP_W = (CNT_W > psq_pkg::POS_W) ? CNT_W : psq_pkg::POS_W;

  logic [CMP_W-1:0] ext_pos;
  logic [CMP_W-1:0] ext_cnt;
  logic             full;

  assign ext_pos = CMP_W'(position);
  assign ext_cnt = CMP_W'(count);
  assign full    = (ext_cnt >= CMP_W'(CAPACITY));

  always_comb begin
    status    = psq_pkg::ST_DONE;
    cmd.op    = psq_pkg::CMD_NONE;
    cmd.pos   = position;
    count_nxt = count;
    unique case (action)
      psq_pkg::ACT_APPEND: begin
        if (full) begin
          status = psq_pkg::ST_FULL;
        end else begin
          cmd.op    = psq_pkg::CMD_APPEND;
          count_nxt = count + CNT_W'(1);
        end
      end
      psq_pkg::ACT_INSERT: begin
        if (ext_pos > ext_cnt) begin
          status = psq_pkg::ST_BADPOS;
        end else if (full) begin
          status = psq_pkg::ST_FULL;
        end else begin
          cmd.op    = psq_pkg::CMD_INSERT;
          count_nxt = count + CNT_W'(1);
        end
      end
      psq_pkg::ACT_REPLACE: begin
        if (ext_pos >= ext_cnt) begin
          status = psq_pkg::ST_BADPOS;
        end else begin
          cmd.op = psq_pkg::CMD_REPLACE;
        end
      end
      psq_pkg::ACT_REMOVE: begin
        if (ext_pos >= ext_cnt) begin
          status = psq_pkg::ST_BADPOS;
        end else begin
          cmd.op    = psq_pkg::CMD_REMOVE;
          count_nxt = count - CNT_W'(1);
        end
      end
      default: begin
        status = psq_pkg::ST_BADPOS;
      end
    endcase
    if (!accept) begin
      cmd.op    = psq_pkg::CMD_NONE;
      count_nxt = count;
    end
  end

endmodule

FILE: rtl/psq_cell.sv
// One storage cell of the sequence chain. It loads the new value, takes its
// lower or upper neighbor's entry, or holds, from its own position and count compares.
// Depends on psq_pkg.
module psq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  psq_pkg::cell_cmd_t                cmd,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [psq_pkg::DATA_W-1:0] wr_value,
  input  logic signed [psq_pkg::DATA_W-1:0] lower_data,
  input  logic signed [psq_pkg::DATA_W-1:0] upper_data,
  output logic signed [psq_pkg::DATA_W-1:0] data
);

  localparam bit REACHABLE = (INDEX < (2 ** psq_pkg::POS_W));

  logic signed [psq_pkg::DATA_W-1:0] data_r;
  logic signed [psq_pkg::DATA_W-1:0] data_nxt;
  logic                              at_pos;
  logic                              above_pos;
  logic                              at_end;

  assign at_pos    = REACHABLE && (cmd.pos == psq_pkg::POS_W'(INDEX));
  assign above_pos = !REACHABLE || (psq_pkg::POS_W'(INDEX) > cmd.pos);
  assign at_end    = (count == CNT_W'(INDEX));

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      psq_pkg::CMD_APPEND: begin
        if (at_end) data_nxt = wr_value;
      end
      psq_pkg::CMD_INSERT: begin
        if (at_pos) begin
          data_nxt = wr_value;
        end else if (above_pos) begin
          data_nxt = lower_data;
        end
      end
      psq_pkg::CMD_REPLACE: begin
        if (at_pos) data_nxt = wr_value;
      end
      psq_pkg::CMD_REMOVE: begin
        if (at_pos || above_pos) data_nxt = upper_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: rtl/positional_sequence_store_top.sv
// Top level of the positional sequence store: a chain of storage cells,
// the action decode, the old-value select and the result register.
// Depends on psq_pkg, psq_ctrl and psq_cell.
//
//   Channel  Direction  Handshake         Payload
//   in_      input      in_valid/in_stall  action, position, value
//   out_     output     out_valid/out_stall status, old_value, item_count, is_empty
//
// Each transaction is decoded and applied to every cell in the cycle it is accepted;
// one is taken per cycle while in_stall is low; its result appears in the next cycle.
// The result register lets the next transaction in while a result is waiting;
// the input stalls only when a result is held and the output stalls.
// Reset clears the count and the result valid; entry contents are left as they are.
module positional_sequence_store_top #(
  parameter int CAPACITY = psq_pkg::DEF_CAPACITY
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_action,
  input  logic [psq_pkg::POS_W-1:0]               in_position,
  input  logic signed [psq_pkg::DATA_W-1:0]       in_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              out_status,
  output logic signed [psq_pkg::DATA_W-1:0]       out_old_value,
  output logic [psq_pkg::COUNT_OUT_W-1:0]         out_item_count,
  output logic                                    out_is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RD_N  = (CAPACITY < (2 ** psq_pkg::POS_W)) ? CAPACITY
                                                            : (2 ** psq_pkg::POS_W);

  logic                              accept;
  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  psq_pkg::cell_cmd_t                cmd;
  psq_pkg::status_t                  status;
  logic signed [psq_pkg::DATA_W-1:0] cell_q [CAPACITY];
  logic signed [psq_pkg::DATA_W-1:0] rd_value;

  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  logic [1:0]                            out_status_r;
  logic signed [psq_pkg::DATA_W-1:0]     out_old_value_r;
  logic [psq_pkg::COUNT_OUT_W-1:0]       out_item_count_r;
  logic                                  out_is_empty_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  psq_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .accept    (accept),
    .action    (psq_pkg::action_t'(in_action)),
    .position  (in_position),
    .count     (count_r),
    .cmd       (cmd),
    .status    (status),
    .count_nxt (count_nxt)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [psq_pkg::DATA_W-1:0] lower_data;
    logic signed [psq_pkg::DATA_W-1:0] upper_data;

    if (i == 0) begin : g_first
      assign lower_data = '0;
    end else begin : g_lower
      assign lower_data = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_data = '0;
    end else begin : g_upper
      assign upper_data = cell_q[i+1];
    end

    psq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .wr_value   (in_value),
      .lower_data (lower_data),
      .upper_data (upper_data),
      .data       (cell_q[i])
    );
  end

  always_comb begin
    rd_value = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (in_position == psq_pkg::POS_W'(k)) rd_value = cell_q[k];
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r     <= status;
      out_old_value_r  <= ((status == psq_pkg::ST_DONE) &&
                           ((cmd.op == psq_pkg::CMD_REPLACE) ||
                            (cmd.op == psq_pkg::CMD_REMOVE))) ? rd_value : '0;
      out_item_count_r <= psq_pkg::COUNT_OUT_W'(count_nxt);
      out_is_empty_r   <= (count_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_old_value  = out_old_value_r;
  assign out_item_count = out_item_count_r;
  assign out_is_empty   = out_is_empty_r;

endmodule

FILE: rtl/psq_checker.sv
// Port-level checker for the positional sequence store, bound to the top level.
// Depends on psq_pkg and positional_sequence_store_top.
module psq_checker #(
  parameter int CAPACITY = psq_pkg::DEF_CAPACITY
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_status,
  input logic signed [psq_pkg::DATA_W-1:0]   out_old_value,
  input logic [psq_pkg::COUNT_OUT_W-1:0]     out_item_count,
  input logic                                out_is_empty
);

  localparam bit COUNT_EXACT = (CAPACITY < (2 ** psq_pkg::COUNT_OUT_W));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_old_value) && $stable(out_item_count))
    else $error("Stalled result transaction changed or dropped.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted transaction produced no result.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != psq_pkg::ST_DONE) |-> (out_old_value == '0))
    else $error("Failed transaction reported a nonzero old value.");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && COUNT_EXACT |-> (out_is_empty == (out_item_count == '0)))
    else $error("Empty flag disagrees with the item count.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == psq_pkg::ST_FULL) |->
      (out_item_count == psq_pkg::COUNT_OUT_W'(CAPACITY)))
    else $error("Full status reported with a count below capacity.");

endmodule

bind positional_sequence_store_top psq_checker #(
  .CAPACITY (CAPACITY)
) u_psq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_old_value  (out_old_value),
  .out_item_count (out_item_count),
  .out_is_empty   (out_is_empty)
);
